@@ rtl/cfrb_pkg.sv @@
// ----------------------------------------------------------------------------
// cfrb_pkg
// Command codes, target select codes and decode types of the command-framed
// register bank.
// ----------------------------------------------------------------------------
package cfrb_pkg;

    localparam int BYTE_W = 8;

    // Command bytes, recognized only while waiting for a command
    localparam logic [BYTE_W-1:0] CMD_SET_SENSOR = 8'h84;
    localparam logic [BYTE_W-1:0] CMD_SET_WHEEL  = 8'h85;
    localparam logic [BYTE_W-1:0] CMD_SET_ARM    = 8'h86;
    localparam logic [BYTE_W-1:0] CMD_SET_TAG    = 8'hAB;
    localparam logic [BYTE_W-1:0] CMD_GET_WHEEL  = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_GET_ARM    = 8'h06;

    localparam logic [BYTE_W-1:0] WHEEL_RESET = 8'hAA;

    typedef enum logic [2:0] {
        SEL_NONE   = 3'd0,
        SEL_SENSOR = 3'd1,
        SEL_ARM    = 3'd2,
        SEL_WHEEL  = 3'd3,
        SEL_TAG    = 3'd4
    } sel_t;

    // Actions taken on one accepted byte
    typedef struct packed {
        logic enter_payload;   // command selects a target, payload follows
        sel_t sel;             // target chosen by the command
        logic rd_wheel;        // return stored wheel byte
        logic rd_arm;          // return stored arm byte
        logic wr_sensor;
        logic wr_arm;
        logic wr_wheel;
        logic wr_tag;
        logic drop;            // payload with no target: back to command
    } dec_t;

endpackage

@@ rtl/command_framed_register_bank.sv @@
// ----------------------------------------------------------------------------
// command_framed_register_bank
// Takes SPI slave bytes one per transfer. While waiting for a command, 0x84,
// 0x85 and 0x86 select the sensor, wheel or arm register for the next byte,
// 0xAB selects the tag store for the next TAG_LENGTH bytes, and 0x05 / 0x06
// return the stored wheel or arm byte as one result transfer; other bytes are
// ignored. After the payload the block waits for a command again. Each byte
// is handled in the cycle it is accepted and a read result appears on m_ in
// the next cycle, held in one output register; a new byte is taken every
// cycle unless a result sits in that register and m_ready is low. The wheel
// register resets to 0xAA, sensor and arm to 0; the tag store is not cleared.
// ----------------------------------------------------------------------------
module command_framed_register_bank #(
    parameter int TAG_LENGTH = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cfrb_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cfrb_pkg::BYTE_W-1:0] m_tx_byte
);
    import cfrb_pkg::*;

    localparam int IDX_W = (TAG_LENGTH > 1) ? $clog2(TAG_LENGTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAG_LENGTH - 1);

    logic              awaiting_reg, awaiting_next;
    sel_t              target_reg, target_next;
    logic [BYTE_W-1:0] sensor_reg, sensor_next;
    logic [BYTE_W-1:0] arm_reg, arm_next;
    logic [BYTE_W-1:0] wheel_reg, wheel_next;
    logic [IDX_W-1:0]  tag_index_reg, tag_index_next;
    logic [BYTE_W-1:0] tag_reg [TAG_LENGTH];
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] tx_reg, tx_next;

    logic accept;
    logic tag_last;
    dec_t dec;

    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_tx_byte = tx_reg;

    cfrb_decoder u_decoder (
        .rx_byte          (s_rx_byte),
        .awaiting_command (awaiting_reg),
        .target_select    (target_reg),
        .dec              (dec)
    );

    assign tag_last = (tag_index_reg >= LAST_IDX);

    always_comb begin
        awaiting_next  = awaiting_reg;
        target_next    = target_reg;
        sensor_next    = sensor_reg;
        arm_next       = arm_reg;
        wheel_next     = wheel_reg;
        tag_index_next = tag_index_reg;
        out_valid_next = out_valid_reg && !m_ready;
        tx_next        = tx_reg;
        if (accept) begin
            if (dec.enter_payload) begin
                awaiting_next = 1'b0;
                target_next   = dec.sel;
            end
            if (dec.rd_wheel || dec.rd_arm) begin
                out_valid_next = 1'b1;
                tx_next        = dec.rd_wheel ? wheel_reg : arm_reg;
            end
            if (dec.wr_sensor) begin
                sensor_next = s_rx_byte;
            end
            if (dec.wr_arm) begin
                arm_next = s_rx_byte;
            end
            if (dec.wr_wheel) begin
                wheel_next = s_rx_byte;
            end
            if (dec.wr_sensor || dec.wr_arm || dec.wr_wheel || dec.drop) begin
                awaiting_next = 1'b1;
            end
            if (dec.wr_tag) begin
                if (tag_last) begin
                    tag_index_next = '0;
                    awaiting_next  = 1'b1;
                end else begin
                    tag_index_next = tag_index_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg  <= 1'b1;
            target_reg    <= SEL_NONE;
            sensor_reg    <= '0;
            arm_reg       <= '0;
            wheel_reg     <= WHEEL_RESET;
            tag_index_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            awaiting_reg  <= awaiting_next;
            target_reg    <= target_next;
            sensor_reg    <= sensor_next;
            arm_reg       <= arm_next;
            wheel_reg     <= wheel_next;
            tag_index_reg <= tag_index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        tx_reg <= tx_next;
        if (accept && dec.wr_tag && (32'(tag_index_reg) < TAG_LENGTH)) begin
            tag_reg[tag_index_reg] <= s_rx_byte;
        end
    end

    // A result only appears after an accepted transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(accept))
        else $error("result appeared without an accepted transfer");

    // A payload phase always has a target
    assert property (@(posedge aclk) disable iff (!aresetn)
        !awaiting_reg |-> (target_reg != SEL_NONE))
        else $error("payload phase with no target selected");

    // Tag index stays in range and moves only during a tag payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tag_index_reg != '0) |-> (!awaiting_reg && (target_reg == SEL_TAG)
            && (32'(tag_index_reg) < TAG_LENGTH)))
        else $error("tag index outside a tag payload");

endmodule

@@ rtl/cfrb_decoder.sv @@
// ----------------------------------------------------------------------------
// cfrb_decoder
// Decodes one received byte against the current framing state into the set
// of register and result actions for that byte.
// ----------------------------------------------------------------------------
module cfrb_decoder (
    input  logic [cfrb_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        awaiting_command,
    input  cfrb_pkg::sel_t              target_select,
    output cfrb_pkg::dec_t              dec
);
    import cfrb_pkg::*;

    always_comb begin
        dec = '0;
        dec.sel = SEL_NONE;
        if (awaiting_command) begin
            case (rx_byte)
                CMD_SET_SENSOR: begin
                    dec.enter_payload = 1'b1;
                    dec.sel           = SEL_SENSOR;
                end
                CMD_SET_WHEEL: begin
                    dec.enter_payload = 1'b1;
                    dec.sel           = SEL_WHEEL;
                end
                CMD_SET_ARM: begin
                    dec.enter_payload = 1'b1;
                    dec.sel           = SEL_ARM;
                end
                CMD_SET_TAG: begin
                    dec.enter_payload = 1'b1;
                    dec.sel           = SEL_TAG;
                end
                CMD_GET_WHEEL: dec.rd_wheel = 1'b1;
                CMD_GET_ARM:   dec.rd_arm   = 1'b1;
                default: ;
            endcase
        end else begin
            case (target_select)
                SEL_SENSOR: dec.wr_sensor = 1'b1;
                SEL_ARM:    dec.wr_arm    = 1'b1;
                SEL_WHEEL:  dec.wr_wheel  = 1'b1;
                SEL_TAG:    dec.wr_tag    = 1'b1;
                default:    dec.drop      = 1'b1;
            endcase
        end
    end

endmodule
